>>> rtl/pmrr_pkg.sv
// ----------------------------------------------------------------------------
// pmrr_pkg
// Types and constants shared by the ranged Park-Miller generator and its
// checker.
// ----------------------------------------------------------------------------
`default_nettype none

package pmrr_pkg;

  localparam int SEED_W       = 31;
  localparam int DATA_W       = 32;
  localparam int MULT_W       = 16;
  localparam int MULT_IDX_W   = $clog2(MULT_W);
  localparam int CNT_W        = $clog2(SEED_W);
  localparam int WARMUP_STEPS = 10;
  localparam int WARM_W       = (WARMUP_STEPS > 1) ? $clog2(WARMUP_STEPS) : 1;

  localparam logic [SEED_W-1:0] PM_MODULUS    = 31'h7FFF_FFFF;
  localparam logic [MULT_W-1:0] PM_MULT       = 16'd48271;
  localparam logic [SEED_W-1:0] ZERO_SEED_SUB = 31'd97997;
  localparam logic [SEED_W-1:0] RESET_SEED    = 31'd1;

  localparam logic [1:0] OP_RAW_SIGNED     = 2'd0;
  localparam logic [1:0] OP_SIGNED_RANGE   = 2'd1;
  localparam logic [1:0] OP_RAW_UNSIGNED   = 2'd2;
  localparam logic [1:0] OP_UNSIGNED_BOUND = 2'd3;

  typedef enum logic [2:0] {
    ST_WARM,
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]               operation;
    logic signed [DATA_W-1:0] low_bound;
    logic signed [DATA_W-1:0] high_bound;
  } cmd_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] draw_value;
    logic                     range_error;
  } res_t;

endpackage

`default_nettype wire

>>> rtl/park_miller_ranged_random_top.sv
// ----------------------------------------------------------------------------
// park_miller_ranged_random_top
// Two minimal-standard Park-Miller streams (48271 * s mod 2^31-1) with an
// optional bit-serial range reduction of each draw.
// ----------------------------------------------------------------------------
//
//   channel   signals                       transfer when
//   cmd       cmd_valid, cmd_stall, cmd     cmd_valid && !cmd_stall
//   res       res_valid, res_stall, res     res_valid && !res_stall
//   cfg       cfg_write, cfg_data           cfg_write
//
// the stream update runs MSB first over the 16 multiplier bits, one bit a
// cycle: rotate, conditional add of src, conditional subtract of modulus
// raw draws and errors go from transfer through ST_MUL and ST_DONE to the
// result register; ranged draws add a restoring remainder in ST_DIV
// after reset and after a seed write, warm-up runs WARMUP_STEPS stream
// updates with cmd_stall high
// one command at a time; a new command transfers while a result still waits
//
`default_nettype none

module park_miller_ranged_random_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cmd_valid,
  output logic                         cmd_stall,
  input  pmrr_pkg::cmd_t               cmd,
  output logic                         res_valid,
  input  logic                         res_stall,
  output pmrr_pkg::res_t               res,
  input  logic                         cfg_write,
  input  logic [pmrr_pkg::SEED_W-1:0]  cfg_data
);
  import pmrr_pkg::*;

  localparam logic   WARM_ON     = (WARMUP_STEPS != 0);
  localparam state_t RESET_STATE = WARM_ON ? ST_WARM : ST_IDLE;

  state_t state, state_next;

  logic [SEED_W-1:0]   sstate;
  logic [SEED_W-1:0]   ustate;
  logic [SEED_W-1:0]   src;
  logic [SEED_W-1:0]   acc;
  logic [SEED_W-1:0]   acc_next;
  logic [SEED_W-1:0]   quo_bits;
  logic [CNT_W-1:0]    cnt;
  logic [WARM_W-1:0]   warm_cnt;
  logic [1:0]          op;
  logic [DATA_W-1:0]   lo;
  logic [DATA_W:0]     span;
  logic [DATA_W:0]     span_in;
  logic                err;
  logic                err_in;
  logic [DATA_W-1:0]   draw;
  logic [DATA_W-1:0]   rem;
  logic [DATA_W-1:0]   rem_next;
  logic [DATA_W-1:0]   rem_shift;
  logic [SEED_W-1:0]   seed_in;
  logic [SEED_W-1:0]   rot;
  logic [SEED_W:0]     mul_sum;
  logic [MULT_IDX_W-1:0] mul_idx;
  logic                mul_bit;
  logic                mul_last;
  logic                div_last;
  logic                warm_last;
  logic                res_load;
  res_t                res_d;

  // seed load
  assign seed_in = (cfg_data == '0) ? ZERO_SEED_SUB : cfg_data;

  // one bit of 48271 * src mod 2^31-1
  assign mul_idx  = MULT_IDX_W'(MULT_W - 1) - cnt[MULT_IDX_W-1:0];
  assign mul_bit  = PM_MULT[mul_idx];
  assign rot      = {acc[SEED_W-2:0], acc[SEED_W-1]};
  assign mul_sum  = {1'b0, rot} + (mul_bit ? {1'b0, src} : {(SEED_W+1){1'b0}});
  assign acc_next = (mul_sum >= {1'b0, PM_MODULUS}) ?
                    SEED_W'(mul_sum - {1'b0, PM_MODULUS}) : mul_sum[SEED_W-1:0];

  // one bit of restoring remainder
  assign rem_shift = {rem[DATA_W-2:0], quo_bits[SEED_W-1]};
  assign rem_next  = ({1'b0, rem_shift} >= span) ?
                     DATA_W'({1'b0, rem_shift} - span) : rem_shift;

  assign mul_last  = (cnt == CNT_W'(MULT_W - 1));
  assign div_last  = (cnt == CNT_W'(SEED_W - 1));
  assign warm_last = (warm_cnt == WARM_W'(WARMUP_STEPS - 1));

  // range setup at command transfer
  always_comb begin
    span_in = '0;
    err_in  = 1'b0;
    case (cmd.operation)
      OP_SIGNED_RANGE: begin
        span_in = {cmd.high_bound[DATA_W-1], cmd.high_bound}
                - {cmd.low_bound[DATA_W-1], cmd.low_bound} + (DATA_W+1)'(1);
        err_in  = (cmd.low_bound > cmd.high_bound);
      end
      OP_UNSIGNED_BOUND: begin
        span_in = {1'b0, cmd.high_bound};
        err_in  = (cmd.high_bound == '0);
      end
      default: begin
        span_in = '0;
        err_in  = 1'b0;
      end
    endcase
  end

  assign res_d = '{draw_value: draw, range_error: err};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= RESET_STATE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd_stall  = (state != ST_IDLE);
    res_load   = 1'b0;
    case (state)
      ST_WARM: begin
        if (mul_last && warm_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (cmd_valid) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        if (mul_last) begin
          state_next = (!op[0] || err) ? ST_DONE : ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_last) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!res_valid || !res_stall) begin
          res_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = RESET_STATE;
      end
    endcase
    if (cfg_write) begin
      state_next = WARM_ON ? ST_WARM : ST_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sstate    <= RESET_SEED;
      ustate    <= RESET_SEED;
      src       <= RESET_SEED;
      acc       <= '0;
      cnt       <= '0;
      warm_cnt  <= '0;
      res_valid <= 1'b0;
    end else begin
      if (res_load) begin
        res_valid <= 1'b1;
        res       <= res_d;
      end else if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end

      if (cfg_write) begin
        sstate   <= seed_in;
        ustate   <= seed_in;
        src      <= seed_in;
        acc      <= '0;
        cnt      <= '0;
        warm_cnt <= '0;
      end else begin
        case (state)
          ST_WARM: begin
            if (mul_last) begin
              acc      <= '0;
              cnt      <= '0;
              src      <= acc_next;
              sstate   <= acc_next;
              ustate   <= acc_next;
              warm_cnt <= warm_cnt + WARM_W'(1);
            end else begin
              acc <= acc_next;
              cnt <= cnt + CNT_W'(1);
            end
          end
          ST_IDLE: begin
            if (cmd_valid) begin
              op   <= cmd.operation;
              lo   <= cmd.low_bound;
              span <= span_in;
              err  <= err_in;
              src  <= cmd.operation[1] ? ustate : sstate;
              acc  <= '0;
              cnt  <= '0;
            end
          end
          ST_MUL: begin
            acc <= acc_next;
            if (mul_last) begin
              cnt      <= '0;
              quo_bits <= acc_next;
              rem      <= '0;
              if (op[1]) begin
                ustate <= acc_next;
              end else begin
                sstate <= acc_next;
              end
              if (err) begin
                draw <= (op == OP_SIGNED_RANGE) ? lo : '0;
              end else begin
                draw <= {1'b0, acc_next};
              end
            end else begin
              cnt <= cnt + CNT_W'(1);
            end
          end
          ST_DIV: begin
            quo_bits <= {quo_bits[SEED_W-2:0], 1'b0};
            rem      <= rem_next;
            cnt      <= cnt + CNT_W'(1);
            if (div_last) begin
              draw <= (op == OP_UNSIGNED_BOUND) ? rem_next : lo + rem_next;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/pmrr_check.sv
// ----------------------------------------------------------------------------
// pmrr_check
// Port-level checks on the ranged Park-Miller generator, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module pmrr_check (
  input logic           clk,
  input logic           rst,
  input logic           cmd_valid,
  input logic           cmd_stall,
  input logic           res_valid,
  input logic           res_stall,
  input pmrr_pkg::res_t res,
  input logic           cfg_write
);
  import pmrr_pkg::*;

  // a stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res))
    else $error("stalled result changed or dropped");

  // one command at a time
  a_cmd_busy: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_stall && !cfg_write |=> cmd_stall)
    else $error("command taken while another is in flight");

  // a seed write starts warm-up
  a_cfg_warm: assert property (@(posedge clk) disable iff (rst)
    (WARMUP_STEPS > 0) && cfg_write |=> cmd_stall)
    else $error("seed write did not start warm-up");

  // results appear only from a busy block
  a_res_src: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(cmd_stall))
    else $error("result appeared without work in flight");

endmodule

bind park_miller_ranged_random_top pmrr_check u_pmrr_check (.*);

`default_nettype wire
